// ===== hdl/cpu_interrupt_exception_entry_unit_assert.svh =====
// assertion macros for the exception entry unit
`ifndef CPU_INTERRUPT_EXCEPTION_ENTRY_UNIT_ASSERT_SVH
`define CPU_INTERRUPT_EXCEPTION_ENTRY_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CIEU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cieu same-cycle check failed");
// next-cycle implication
`define CIEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cieu next-cycle check failed");
`else
`define CIEU_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CIEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/cieu_pkg.sv =====
package cieu_pkg;

    // input operation codes
    localparam logic [1:0] OP_IRQ   = 2'd0;
    localparam logic [1:0] OP_POLL  = 2'd1;
    localparam logic [1:0] OP_VEC   = 2'd2;
    localparam logic [1:0] OP_VDATA = 2'd3;

    // result kinds
    localparam logic [2:0] K_WL = 3'd0;
    localparam logic [2:0] K_WW = 3'd1;
    localparam logic [2:0] K_RL = 3'd2;
    localparam logic [2:0] K_ST = 3'd3;
    localparam logic [2:0] K_PC = 3'd4;

    // status word bit positions
    localparam int SR_T_BIT    = 15;
    localparam int SR_S_BIT    = 13;
    localparam int SR_MASK_LSB = 8;

    localparam logic [2:0]  LEVEL_NMI   = 3'd7;
    localparam logic [31:0] LONG_BYTES  = 32'd4;
    localparam logic [31:0] WORD_BYTES  = 32'd2;

    localparam int          BASE_W          = 8;
    localparam logic [7:0]  AUTOVECTOR_BASE_DEF = 8'd24;

    // one pending exception entry, all beats worth
    typedef struct packed {
        logic        is_pc;     // vector data: single new pc beat
        logic [31:0] pc;        // pushed pc, or new pc
        logic [15:0] push_sr;
        logic [31:0] addr_l;
        logic [31:0] addr_w;
        logic [31:0] vaddr;
        logic [15:0] fin_sr;
        logic [31:0] osp;
        logic        stopc;
    } t_entry;

    // decision for one item and its effect on the state
    typedef struct packed {
        logic       has_entry;
        logic       has_pc;
        logic [2:0] nxt_pend;
        logic       nxt_await;
    } t_decide;

endpackage

// ===== hdl/cieu_calc.sv =====
module cieu_calc
    import cieu_pkg::*;
#(
    parameter logic [BASE_W-1:0] AUTOVECTOR_BASE = AUTOVECTOR_BASE_DEF
) (
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_level,
    input  logic [7:0]  i_vector_number,
    input  logic [31:0] i_old_pc,
    input  logic [31:0] i_cur_pc,
    input  logic [15:0] i_cur_sr,
    input  logic [31:0] i_active_sp,
    input  logic [31:0] i_other_sp,
    input  logic        i_stopped,
    input  logic        i_frozen,
    input  logic [31:0] i_read_data,
    input  logic [2:0]  i_pend,
    input  logic        i_await,
    output t_entry      o_ent,
    output t_decide     o_dec
);

    logic [2:0]  mask;
    logic        take_irq;
    logic        take_poll;
    logic        is_int;
    logic        do_entry;
    logic [2:0]  ilvl;
    logic        user;
    logic [31:0] asp;
    logic [15:0] sr_s;
    logic [31:0] vec_base;

    // interrupt acceptance
    always_comb begin
        mask      = i_cur_sr[SR_MASK_LSB +: 3];
        take_irq  = (i_op == OP_IRQ) && ((mask < i_level) || (i_level == LEVEL_NMI))
                    && !i_frozen;
        take_poll = (i_op == OP_POLL) && (i_pend != 3'd0) && (mask < i_pend) && !i_frozen;
        is_int    = take_irq || take_poll;
        do_entry  = is_int || (i_op == OP_VEC);
        ilvl      = take_irq ? i_level : i_pend;
    end

    // state effect
    always_comb begin
        o_dec.has_entry = do_entry;
        o_dec.has_pc    = (i_op == OP_VDATA) && i_await;
        if (is_int) begin
            o_dec.nxt_pend = 3'd0;
        end else if (i_op == OP_IRQ) begin
            o_dec.nxt_pend = i_level;
        end else begin
            o_dec.nxt_pend = i_pend;
        end
        if (do_entry) begin
            o_dec.nxt_await = 1'b1;
        end else if (i_op == OP_VDATA) begin
            o_dec.nxt_await = 1'b0;
        end else begin
            o_dec.nxt_await = i_await;
        end
    end

    // stack swap, pushes and vector address
    always_comb begin
        user     = !i_cur_sr[SR_S_BIT];
        asp      = user ? i_other_sp : i_active_sp;
        sr_s     = i_cur_sr | (16'd1 << SR_S_BIT);
        vec_base = {{(32-BASE_W){1'b0}}, AUTOVECTOR_BASE} + {29'd0, ilvl} - 32'd1;

        o_ent.is_pc   = (i_op == OP_VDATA);
        o_ent.stopc   = is_int && i_stopped;
        if (i_op == OP_VDATA) begin
            o_ent.pc = i_read_data;
        end else if (is_int) begin
            o_ent.pc = i_stopped ? (i_cur_pc + LONG_BYTES) : i_cur_pc;
        end else begin
            o_ent.pc = i_old_pc;
        end
        o_ent.push_sr = sr_s;
        o_ent.addr_l  = asp - LONG_BYTES;
        o_ent.addr_w  = asp - LONG_BYTES - WORD_BYTES;
        o_ent.vaddr   = is_int ? {vec_base[29:0], 2'b00} : {22'd0, i_vector_number, 2'b00};
        o_ent.osp     = user ? i_active_sp : i_other_sp;
        o_ent.fin_sr  = sr_s;
        if (is_int) begin
            o_ent.fin_sr[SR_T_BIT]           = 1'b0;
            o_ent.fin_sr[SR_MASK_LSB +: 3]   = ilvl;
        end
    end

endmodule

// ===== hdl/cpu_interrupt_exception_entry_unit.sv =====
// an accepted beat is registered in the input register, and its result is loaded into the entry register
// throughput: one input beat per cycle while no results are due; an exception
// entry sends four result beats and a vector data beat one, one per cycle on the
// output port while m_axis_tready is high; the next entry loads as the last beat is taken
// reset: synchronous active low; clears pending level, outstanding vector read flag
module cpu_interrupt_exception_entry_unit
    import cieu_pkg::*;
#(
    parameter logic [BASE_W-1:0] AUTOVECTOR_BASE = AUTOVECTOR_BASE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // level[2:0], vector_number[10:3], old_pc[42:11], cur_pc[74:43], cur_sr[90:75],
    // active_sp[122:91], other_sp[154:123], stopped[155], frozen[156],
    // read_data[188:157], zero pad[191:189]
    input  logic [191:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // address[31:0], data[63:32], new_sr[79:64], new_active_sp[111:80],
    // new_other_sp[143:112], stop_cleared[144], zero pad[151:145]
    output logic [151:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

`include "cpu_interrupt_exception_entry_unit_assert.svh"

    logic         r_in_v;
    logic         n_in_v;
    logic [1:0]   r_in_op;
    logic [191:0] r_in_data;
    logic [2:0]   r_pend;
    logic [2:0]   n_pend;
    logic         r_await;
    logic         n_await;
    logic         r_ent_v;
    logic         n_ent_v;
    logic [1:0]   r_idx;
    logic [1:0]   n_idx;
    t_entry       r_ent;
    t_entry       calc_ent;
    t_decide      calc_dec;

    logic s_fire;
    logic m_fire;
    logic ent_last;
    logic ent_free;
    logic produces;
    logic in_move;
    logic ent_load;

    // result for the item in the input register
    cieu_calc #(
        .AUTOVECTOR_BASE(AUTOVECTOR_BASE)
    ) u_calc (
        .i_op           (r_in_op),
        .i_level        (r_in_data[2:0]),
        .i_vector_number(r_in_data[10:3]),
        .i_old_pc       (r_in_data[42:11]),
        .i_cur_pc       (r_in_data[74:43]),
        .i_cur_sr       (r_in_data[90:75]),
        .i_active_sp    (r_in_data[122:91]),
        .i_other_sp     (r_in_data[154:123]),
        .i_stopped      (r_in_data[155]),
        .i_frozen       (r_in_data[156]),
        .i_read_data    (r_in_data[188:157]),
        .i_pend         (r_pend),
        .i_await        (r_await),
        .o_ent          (calc_ent),
        .o_dec          (calc_dec)
    );

    // handshake and flow control
    always_comb begin
        m_fire        = r_ent_v && m_axis_tready;
        ent_last      = r_ent.is_pc || (r_idx == 2'd3);
        ent_free      = !r_ent_v || (m_fire && ent_last);
        produces      = calc_dec.has_entry || calc_dec.has_pc;
        in_move       = r_in_v && (!produces || ent_free);
        ent_load      = in_move && produces;
        s_axis_tready = !r_in_v || in_move;
        s_fire        = s_axis_tvalid && s_axis_tready;
    end

    // next control state
    always_comb begin
        n_in_v  = r_in_v;
        n_pend  = r_pend;
        n_await = r_await;
        n_ent_v = r_ent_v;
        n_idx   = r_idx;
        if (s_fire) begin
            n_in_v = 1'b1;
        end else if (in_move) begin
            n_in_v = 1'b0;
        end
        if (in_move) begin
            n_pend  = calc_dec.nxt_pend;
            n_await = calc_dec.nxt_await;
        end
        if (ent_load) begin
            n_ent_v = 1'b1;
            n_idx   = 2'd0;
        end else if (m_fire) begin
            n_idx = r_idx + 2'd1;
            if (ent_last) begin
                n_ent_v = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_pend  <= 3'd0;
            r_await <= 1'b0;
            r_ent_v <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_in_v  <= n_in_v;
            r_pend  <= n_pend;
            r_await <= n_await;
            r_ent_v <= n_ent_v;
            r_idx   <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_op   <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
        if (ent_load) begin
            r_ent <= calc_ent;
        end
    end

    // output beat select
    always_comb begin
        m_axis_tvalid = r_ent_v;
        m_axis_tdata  = '0;
        m_axis_tlast  = 1'b0;
        m_axis_tuser  = K_PC;
        if (r_ent.is_pc) begin
            m_axis_tuser        = K_PC;
            m_axis_tdata[63:32] = r_ent.pc;
            m_axis_tlast        = 1'b1;
        end else begin
            unique case (r_idx)
                2'd0: begin
                    m_axis_tuser        = K_WL;
                    m_axis_tdata[31:0]  = r_ent.addr_l;
                    m_axis_tdata[63:32] = r_ent.pc;
                end
                2'd1: begin
                    m_axis_tuser        = K_WW;
                    m_axis_tdata[31:0]  = r_ent.addr_w;
                    m_axis_tdata[63:32] = {16'd0, r_ent.push_sr};
                end
                2'd2: begin
                    m_axis_tuser        = K_RL;
                    m_axis_tdata[31:0]  = r_ent.vaddr;
                end
                default: begin
                    m_axis_tuser          = K_ST;
                    m_axis_tdata[79:64]   = r_ent.fin_sr;
                    m_axis_tdata[111:80]  = r_ent.addr_w;
                    m_axis_tdata[143:112] = r_ent.osp;
                    m_axis_tdata[144]     = r_ent.stopc;
                    m_axis_tlast          = 1'b1;
                end
            endcase
        end
    end

    // final beat of a run is always a state update or a new pc
    `CIEU_ASSERT_SAME(a_last_kind, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, (m_axis_tuser == K_ST) || (m_axis_tuser == K_PC))
    // a drained entry with nothing behind it leaves the output idle
    `CIEU_ASSERT_NEXT(a_drain, i_clk, i_rst_n, m_fire && ent_last && !ent_load, !r_ent_v)
    // a stalled input item leaves the interrupt state alone
    `CIEU_ASSERT_NEXT(a_hold_state, i_clk, i_rst_n, r_in_v && !in_move, $stable(r_pend) && $stable(r_await))
    // a new entry only loads when the output side frees up
    `CIEU_ASSERT_SAME(a_load_free, i_clk, i_rst_n, ent_load && r_ent_v, m_fire && ent_last)

endmodule
